// ----- hdl/command_message_parser_top_assert.svh -----
// Assertion macros for the command message parser.
// Each macro checks on the rising edge of clk and is disabled while rst_n is low.
`ifndef COMMAND_MESSAGE_PARSER_TOP_ASSERT_SVH
`define COMMAND_MESSAGE_PARSER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Check a property that is written out in full.
`define CMP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("command_message_parser_top: assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define CMP_ASSERT_IMPL(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("command_message_parser_top: implication failed");

// Check that a condition implies a consequence in the next cycle.
`define CMP_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("command_message_parser_top: next-cycle implication failed");

`else

`define CMP_ASSERT(label, prop)
`define CMP_ASSERT_IMPL(label, cond, cons)
`define CMP_ASSERT_NEXT(label, cond, cons)

`endif

`endif

// ----- hdl/cmp_pkg.sv -----
`timescale 1ns / 1ps

package cmp_pkg;

  localparam int OUT_VALUES = 4;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_PAD     = 8'h5F;

  typedef struct packed {
    logic [OUT_VALUES-1:0][31:0] value;
    logic [2:0]                  closed;
    logic                        start_cmd;
    logic                        stop_cmd;
  } result_t;

  // Start word: "START" padded with '_'
  function automatic logic [7:0] start_char(input logic [4:0] pos);
    logic [7:0] ch;
    unique case (pos)
      5'd0:    ch = 8'h53;
      5'd1:    ch = 8'h54;
      5'd2:    ch = 8'h41;
      5'd3:    ch = 8'h52;
      5'd4:    ch = 8'h54;
      default: ch = CH_PAD;
    endcase
    return ch;
  endfunction

  // Stop word: "STOP" padded with '_'
  function automatic logic [7:0] stop_char(input logic [4:0] pos);
    logic [7:0] ch;
    unique case (pos)
      5'd0:    ch = 8'h53;
      5'd1:    ch = 8'h54;
      5'd2:    ch = 8'h4F;
      5'd3:    ch = 8'h50;
      default: ch = CH_PAD;
    endcase
    return ch;
  endfunction

endpackage

// ----- hdl/command_message_parser_top.sv -----
`timescale 1ns / 1ps
// A result is registered into out_r, or into skid_r while the output is stalled.
// Throughput: one byte per cycle unless stalled, set by the single state register.
// A two-entry output/skid register lets bytes keep flowing while one result waits.
// Reset: synchronous, active low; it clears all parse state and empties the output.

module command_message_parser_top
  import cmp_pkg::*;
#(
  parameter int VALUE_COUNT    = 4,
  parameter int VALUE_BITS     = 32,
  parameter int COMMAND_LENGTH = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_end_of_message,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_value_a,
  output logic signed [31:0] out_value_b,
  output logic signed [31:0] out_value_c,
  output logic signed [31:0] out_value_d,
  output logic [2:0]         out_values_closed,
  output logic               out_start_command,
  output logic               out_stop_command
);

  `include "command_message_parser_top_assert.svh"

  localparam int CNT_W    = $clog2(VALUE_COUNT + 1);
  localparam int IDX_W    = (VALUE_COUNT > 1) ? $clog2(VALUE_COUNT) : 1;
  localparam int POS_W    = $clog2(COMMAND_LENGTH + 1);
  localparam int REPORTED = (VALUE_COUNT < OUT_VALUES) ? VALUE_COUNT : OUT_VALUES;

  logic                  header_seen_r, header_seen_nxt;
  logic                  negative_pending_r, negative_pending_nxt;
  logic [CNT_W-1:0]      closed_count_r, closed_count_nxt;
  logic [VALUE_BITS-1:0] value_store_r   [VALUE_COUNT];
  logic [VALUE_BITS-1:0] value_store_nxt [VALUE_COUNT];
  logic [POS_W-1:0]      text_position_r, text_position_nxt;
  logic                  start_mismatch_r, start_mismatch_nxt;
  logic                  stop_mismatch_r, stop_mismatch_nxt;
  logic                  zero_seen_r, zero_seen_nxt;

  logic                  out_valid_r, skid_valid_r;
  result_t               out_r, skid_r, result;

  logic                  in_acc, res_fire, out_free;
  logic [7:0]            c;
  logic                  is_digit, room;
  logic [IDX_W-1:0]      cur_idx;
  logic [VALUE_BITS-1:0] digit_val;

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign res_fire  = in_acc && in_end_of_message;
  assign out_free  = !out_valid_r || !out_stall;

  assign c         = in_rx_byte;
  assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign room      = closed_count_r < CNT_W'(VALUE_COUNT);
  assign cur_idx   = closed_count_r[IDX_W-1:0];
  assign digit_val = VALUE_BITS'(c[3:0]);

  always_comb begin
    header_seen_nxt      = header_seen_r;
    negative_pending_nxt = negative_pending_r;
    closed_count_nxt     = closed_count_r;
    value_store_nxt      = value_store_r;
    text_position_nxt    = text_position_r;
    start_mismatch_nxt   = start_mismatch_r;
    stop_mismatch_nxt    = stop_mismatch_r;
    zero_seen_nxt        = zero_seen_r;

    if (in_acc && !zero_seen_r) begin
      priority if (c == CH_NUL) begin
        zero_seen_nxt = 1'b1;
      end else if (c == CH_MINUS) begin
        negative_pending_nxt = 1'b1;
      end else if (c == CH_COLON) begin
        header_seen_nxt = 1'b1;
      end else if (header_seen_r) begin
        priority if (is_digit) begin
          if (room) begin
            for (int k = 0; k < VALUE_COUNT; k++) begin
              if (cur_idx == IDX_W'(k)) begin
                // v*10 + digit, wrapping at the value width
                value_store_nxt[k] = (value_store_r[k] << 3) + (value_store_r[k] << 1)
                                     + digit_val;
              end
            end
          end
        end else if (c == CH_PERCENT) begin
          if (room) begin
            for (int k = 0; k < VALUE_COUNT; k++) begin
              if (cur_idx == IDX_W'(k) && negative_pending_r) begin
                value_store_nxt[k] = -value_store_r[k];
              end
            end
            closed_count_nxt     = closed_count_r + CNT_W'(1);
            negative_pending_nxt = 1'b0;
          end
        end else begin
          if (text_position_r >= POS_W'(COMMAND_LENGTH)) begin
            start_mismatch_nxt = 1'b1;
            stop_mismatch_nxt  = 1'b1;
          end else begin
            if (c != start_char(5'(text_position_r))) start_mismatch_nxt = 1'b1;
            if (c != stop_char(5'(text_position_r)))  stop_mismatch_nxt  = 1'b1;
            text_position_nxt = text_position_r + POS_W'(1);
          end
        end
      end else begin
        // drop bytes ahead of the header
      end
    end
  end

  always_comb begin
    result = '0;
    for (int k = 0; k < REPORTED; k++) begin
      result.value[k] = 32'(value_store_nxt[k]);
    end
    result.closed    = 3'(closed_count_nxt);
    result.start_cmd = !start_mismatch_nxt && (text_position_nxt == POS_W'(COMMAND_LENGTH));
    result.stop_cmd  = !stop_mismatch_nxt && (text_position_nxt == POS_W'(COMMAND_LENGTH));
  end

  // Parse state: clear on reset and after the final byte of each message
  always_ff @(posedge clk) begin
    if (!rst_n || res_fire) begin
      header_seen_r      <= 1'b0;
      negative_pending_r <= 1'b0;
      closed_count_r     <= '0;
      text_position_r    <= '0;
      start_mismatch_r   <= 1'b0;
      stop_mismatch_r    <= 1'b0;
      zero_seen_r        <= 1'b0;
      for (int k = 0; k < VALUE_COUNT; k++) value_store_r[k] <= '0;
    end else begin
      header_seen_r      <= header_seen_nxt;
      negative_pending_r <= negative_pending_nxt;
      closed_count_r     <= closed_count_nxt;
      text_position_r    <= text_position_nxt;
      start_mismatch_r   <= start_mismatch_nxt;
      stop_mismatch_r    <= stop_mismatch_nxt;
      zero_seen_r        <= zero_seen_nxt;
      value_store_r      <= value_store_nxt;
    end
  end

  // Output register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        out_valid_r  <= 1'b1;
        skid_r       <= result;
        skid_valid_r <= res_fire;
      end else begin
        out_r        <= result;
        out_valid_r  <= res_fire;
      end
    end else if (res_fire) begin
      // hold the stalled beat, park the new one
      skid_r       <= result;
      skid_valid_r <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_value_a       = $signed(out_r.value[0]);
  assign out_value_b       = $signed(out_r.value[1]);
  assign out_value_c       = $signed(out_r.value[2]);
  assign out_value_d       = $signed(out_r.value[3]);
  assign out_values_closed = out_r.closed;
  assign out_start_command = out_r.start_cmd;
  assign out_stop_command  = out_r.stop_cmd;

  `CMP_ASSERT_IMPL(a_skid_behind_out, skid_valid_r, out_valid_r)
  `CMP_ASSERT_NEXT(a_result_lands, res_fire && !out_valid_r, out_valid_r)
  `CMP_ASSERT_NEXT(a_clear_after_end, res_fire,
                   closed_count_r == '0 && !header_seen_r && text_position_r == '0)
  `CMP_ASSERT(a_count_bound, closed_count_r <= CNT_W'(VALUE_COUNT))
  `CMP_ASSERT_IMPL(a_pos_bound, 1'b1, text_position_r <= POS_W'(COMMAND_LENGTH))

endmodule
